FILE: rtl/core/rhv_pkg.sv
// shared constants, types and the logo table for the cartridge header checker
package rhv_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int SHOWN_BITS     = 24;
  localparam int OUT_W          = 96;
  localparam int LOGO_LEN       = 48;
  localparam int LOGO_IDX_W     = 6;

  localparam logic [15:0] LOGO_FIRST  = 16'h0104;
  localparam logic [15:0] LOGO_LAST   = 16'h0133;
  localparam logic [15:0] HDR_FIRST   = 16'h0134;
  localparam logic [15:0] HDR_LAST    = 16'h014C;
  localparam logic [15:0] HDR_SUM_AT  = 16'h014D;
  localparam logic [15:0] GLOB_HI_AT  = 16'h014E;
  localparam logic [15:0] GLOB_LO_AT  = 16'h014F;
  localparam logic [15:0] TYPE_AT     = 16'h0147;
  localparam logic [15:0] ROM_CODE_AT = 16'h0148;
  localparam logic [15:0] RAM_CODE_AT = 16'h0149;

  localparam logic [7:0]  ROM_CODE_MAX = 8'd8;
  localparam logic [7:0]  RAM_CODE_MAX = 8'd3;
  localparam logic [13:0] ROM_BASE_KIB = 14'd32;

  // per-byte decode handed from the address stage to the check stage
  typedef struct packed {
    logic in_logo;
    logic in_hdr;
    logic in_glob;
    logic cap_type;
    logic cap_rom;
    logic cap_ram;
    logic cap_hsum;
    logic cap_ghi;
    logic cap_glo;
    logic logo_seen;
    logic hsum_seen;
    logic complete;
    logic last;
  } rhv_ctl_t;

  function automatic logic [7:0] logo_byte(input logic [LOGO_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:  b = 8'hCE;  6'd1:  b = 8'hED;  6'd2:  b = 8'h66;  6'd3:  b = 8'h66;
      6'd4:  b = 8'hCC;  6'd5:  b = 8'h0D;  6'd6:  b = 8'h00;  6'd7:  b = 8'h0B;
      6'd8:  b = 8'h03;  6'd9:  b = 8'h73;  6'd10: b = 8'h00;  6'd11: b = 8'h83;
      6'd12: b = 8'h00;  6'd13: b = 8'h0C;  6'd14: b = 8'h00;  6'd15: b = 8'h0D;
      6'd16: b = 8'h00;  6'd17: b = 8'h08;  6'd18: b = 8'h11;  6'd19: b = 8'h1F;
      6'd20: b = 8'h88;  6'd21: b = 8'h89;  6'd22: b = 8'h00;  6'd23: b = 8'h0E;
      6'd24: b = 8'hDC;  6'd25: b = 8'hCC;  6'd26: b = 8'h6E;  6'd27: b = 8'hE6;
      6'd28: b = 8'hDD;  6'd29: b = 8'hDD;  6'd30: b = 8'hD9;  6'd31: b = 8'h99;
      6'd32: b = 8'hBB;  6'd33: b = 8'hBB;  6'd34: b = 8'h67;  6'd35: b = 8'h63;
      6'd36: b = 8'h6E;  6'd37: b = 8'h0E;  6'd38: b = 8'hEC;  6'd39: b = 8'hCC;
      6'd40: b = 8'hDD;  6'd41: b = 8'hDC;  6'd42: b = 8'h99;  6'd43: b = 8'h9F;
      6'd44: b = 8'hBB;  6'd45: b = 8'hB9;  6'd46: b = 8'h33;  6'd47: b = 8'h3E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/rhv_logo_rom.sv
// logo reference rom, registered synchronous read
module rhv_logo_rom (
  input  logic                            clk,
  input  logic                            en,
  input  logic [rhv_pkg::LOGO_IDX_W-1:0]  idx,
  output logic [7:0]                      data
);

  logic [7:0] mem [rhv_pkg::LOGO_LEN];

  always_comb begin
    for (int i = 0; i < rhv_pkg::LOGO_LEN; i++) begin
      mem[i] = rhv_pkg::logo_byte(rhv_pkg::LOGO_IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= (idx < rhv_pkg::LOGO_IDX_W'(rhv_pkg::LOGO_LEN)) ? mem[idx] : 8'h00;
    end
  end

endmodule

FILE: rtl/core/rhv_front.sv
// address stage: position counter, region decode and logo rom lookup
module rhv_front #(
  parameter int COUNT_BITS = rhv_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  logic                   hold,
  output logic                   s1_valid,
  output logic [7:0]             s1_byte,
  output logic [COUNT_BITS-1:0]  s1_count,
  output rhv_pkg::rhv_ctl_t      s1_ctl,
  output logic [7:0]             logo_ref
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] position;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] logo_off;
  logic                  accept;
  rhv_pkg::rhv_ctl_t     ctl;

  assign accept     = in_valid && !hold;
  assign count_next = (position != CNT_MAX) ? position + 1'b1 : position;
  assign logo_off   = position - COUNT_BITS'(rhv_pkg::LOGO_FIRST);

  always_comb begin
    ctl.in_logo   = position >= COUNT_BITS'(rhv_pkg::LOGO_FIRST) &&
                    position <= COUNT_BITS'(rhv_pkg::LOGO_LAST);
    ctl.in_hdr    = position >= COUNT_BITS'(rhv_pkg::HDR_FIRST) &&
                    position <= COUNT_BITS'(rhv_pkg::HDR_LAST);
    ctl.in_glob   = position != COUNT_BITS'(rhv_pkg::GLOB_HI_AT) &&
                    position != COUNT_BITS'(rhv_pkg::GLOB_LO_AT);
    ctl.cap_type  = position == COUNT_BITS'(rhv_pkg::TYPE_AT);
    ctl.cap_rom   = position == COUNT_BITS'(rhv_pkg::ROM_CODE_AT);
    ctl.cap_ram   = position == COUNT_BITS'(rhv_pkg::RAM_CODE_AT);
    ctl.cap_hsum  = position == COUNT_BITS'(rhv_pkg::HDR_SUM_AT);
    ctl.cap_ghi   = position == COUNT_BITS'(rhv_pkg::GLOB_HI_AT);
    ctl.cap_glo   = position == COUNT_BITS'(rhv_pkg::GLOB_LO_AT);
    ctl.logo_seen = position >= COUNT_BITS'(rhv_pkg::LOGO_LAST);
    ctl.hsum_seen = position >= COUNT_BITS'(rhv_pkg::HDR_SUM_AT);
    ctl.complete  = position >= COUNT_BITS'(rhv_pkg::GLOB_LO_AT);
    ctl.last      = in_last;
  end

  rhv_logo_rom u_rom (
    .clk  (clk),
    .en   (!hold),
    .idx  (logo_off[rhv_pkg::LOGO_IDX_W-1:0]),
    .data (logo_ref)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= in_valid;
      if (accept) begin
        // a new image starts from address zero after the marked byte
        position <= in_last ? '0 : count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_byte  <= in_byte;
      s1_count <= count_next;
      s1_ctl   <= ctl;
    end
  end

endmodule

FILE: rtl/core/rhv_check.sv
// check stage: logo compare, checksums, field capture and the result register
module rhv_check #(
  parameter int COUNT_BITS = rhv_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  input  logic [7:0]                    s1_byte,
  input  logic [COUNT_BITS-1:0]         s1_count,
  input  rhv_pkg::rhv_ctl_t             s1_ctl,
  input  logic [7:0]                    logo_ref,
  input  logic                          out_ready,
  output logic                          hold,
  output logic                          out_valid,
  output logic [rhv_pkg::OUT_W-1:0]     out_data
);

  localparam int WIDE = (COUNT_BITS > rhv_pkg::SHOWN_BITS) ? COUNT_BITS : rhv_pkg::SHOWN_BITS;
  localparam logic [rhv_pkg::SHOWN_BITS-1:0] SHOWN_MAX = '1;

  logic        logo_match, logo_match_next;
  logic [7:0]  header_acc, header_acc_next;
  logic [15:0] global_acc, global_acc_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  rom_code_reg, rom_code_reg_next;
  logic [7:0]  ram_code_reg, ram_code_reg_next;
  logic [7:0]  hdr_sum_reg, hdr_sum_reg_next;
  logic [15:0] glob_sum_reg, glob_sum_reg_next;

  logic        fire;
  logic        ram_ok;
  logic [13:0] rom_kib;
  logic [5:0]  ram_kib;
  logic [WIDE-1:0] count_w;
  logic [rhv_pkg::SHOWN_BITS-1:0] shown;
  logic [88:0] result;

  assign hold = s1_valid && s1_ctl.last && out_valid && !out_ready;
  assign fire = s1_valid && !hold;

  always_comb begin
    logo_match_next   = logo_match;
    header_acc_next   = header_acc;
    global_acc_next   = global_acc;
    type_reg_next     = type_reg;
    rom_code_reg_next = rom_code_reg;
    ram_code_reg_next = ram_code_reg;
    hdr_sum_reg_next  = hdr_sum_reg;
    glob_sum_reg_next = glob_sum_reg;
    if (s1_ctl.in_logo && s1_byte != logo_ref) begin
      logo_match_next = 1'b0;
    end
    if (s1_ctl.in_hdr) begin
      header_acc_next = header_acc - s1_byte - 8'd1;
    end
    if (s1_ctl.in_glob) begin
      global_acc_next = global_acc + {8'h00, s1_byte};
    end
    if (s1_ctl.cap_type) begin
      type_reg_next = s1_byte;
    end
    if (s1_ctl.cap_rom) begin
      rom_code_reg_next = s1_byte;
    end
    if (s1_ctl.cap_ram) begin
      ram_code_reg_next = s1_byte;
    end
    if (s1_ctl.cap_hsum) begin
      hdr_sum_reg_next = s1_byte;
    end
    if (s1_ctl.cap_ghi) begin
      glob_sum_reg_next[15:8] = s1_byte;
    end
    if (s1_ctl.cap_glo) begin
      glob_sum_reg_next[7:0] = s1_byte;
    end
  end

  always_comb begin
    rom_kib = (rom_code_reg_next <= rhv_pkg::ROM_CODE_MAX) ?
              (rhv_pkg::ROM_BASE_KIB << rom_code_reg_next[3:0]) : 14'd0;
    ram_ok  = ram_code_reg_next <= rhv_pkg::RAM_CODE_MAX;
    case (ram_code_reg_next[1:0])
      2'd0:    ram_kib = 6'd0;
      2'd1:    ram_kib = 6'd2;
      2'd2:    ram_kib = 6'd8;
      2'd3:    ram_kib = 6'd32;
      default: ram_kib = 6'd0;
    endcase
    if (!ram_ok) begin
      ram_kib = 6'd0;
    end
    count_w = WIDE'(s1_count);
    shown   = (count_w > WIDE'(SHOWN_MAX)) ? SHOWN_MAX : count_w[rhv_pkg::SHOWN_BITS-1:0];
    result  = {shown,
               glob_sum_reg_next,
               hdr_sum_reg_next,
               ram_ok,
               ram_kib,
               rom_kib,
               rom_code_reg_next,
               type_reg_next,
               s1_ctl.complete,
               s1_ctl.complete && global_acc_next == glob_sum_reg_next,
               s1_ctl.hsum_seen && header_acc_next == hdr_sum_reg_next,
               s1_ctl.logo_seen && logo_match_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      logo_match   <= 1'b1;
      header_acc   <= '0;
      global_acc   <= '0;
      type_reg     <= '0;
      rom_code_reg <= '0;
      ram_code_reg <= '0;
      hdr_sum_reg  <= '0;
      glob_sum_reg <= '0;
    end else if (fire) begin
      if (s1_ctl.last) begin
        // image done, start clean for the next one
        logo_match   <= 1'b1;
        header_acc   <= '0;
        global_acc   <= '0;
        type_reg     <= '0;
        rom_code_reg <= '0;
        ram_code_reg <= '0;
        hdr_sum_reg  <= '0;
        glob_sum_reg <= '0;
      end else begin
        logo_match   <= logo_match_next;
        header_acc   <= header_acc_next;
        global_acc   <= global_acc_next;
        type_reg     <= type_reg_next;
        rom_code_reg <= rom_code_reg_next;
        ram_code_reg <= ram_code_reg_next;
        hdr_sum_reg  <= hdr_sum_reg_next;
        glob_sum_reg <= glob_sum_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_ctl.last) begin
      out_data <= rhv_pkg::OUT_W'(result);
    end
  end

endmodule

FILE: rtl/core/rom_header_validator.sv
// top level of the streaming cartridge header checker
// Takes one image byte per cycle on s_axis, addresses counted from zero, and
// gives one registered result request on m_axis for the byte flagged by
// tlast. The sustained rate is one byte per clock: an address stage decodes
// the position and reads the logo rom, a check stage updates the checksums
// and captured fields, and the result register lets the next image stream in
// while a result waits. The input stalls only when a second last byte meets a
// result that has not been taken. No clearing pass is needed after reset.
module rom_header_validator #(
  parameter int COUNT_BITS = rhv_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] rom_byte
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] logo_ok, [1] header_sum_ok, [2] global_sum_ok, [3] header_complete,
  // [11:4] cart_type, [19:12] rom_size_code, [33:20] rom_size_kib,
  // [39:34] ram_size_kib, [40] ram_code_valid, [48:41] stored_header_sum,
  // [64:49] stored_global_sum, [88:65] byte_count, [95:89] zero
  output logic [rhv_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic                  hold;
  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic [COUNT_BITS-1:0] s1_count;
  rhv_pkg::rhv_ctl_t     s1_ctl;
  logic [7:0]            logo_ref;

  assign s_axis_tready = !hold;

  rhv_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .hold     (hold),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .s1_count (s1_count),
    .s1_ctl   (s1_ctl),
    .logo_ref (logo_ref)
  );

  rhv_check #(.COUNT_BITS(COUNT_BITS)) u_check (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .s1_count  (s1_count),
    .s1_ctl    (s1_ctl),
    .logo_ref  (logo_ref),
    .out_ready (m_axis_tready),
    .hold      (hold),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: rtl/core/rhv_checker.sv
// port level checks for the cartridge header checker, bound to the top level
module rhv_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rhv_pkg::OUT_W-1:0] m_axis_tdata
);

  // a pending result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  // the global sum can only pass on a complete header
  a_gsum_complete: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[2] && !m_axis_tdata[3]))
    else $error("global sum ok without complete header");

  // an invalid ram code decodes to zero size
  a_ram_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[40] |-> m_axis_tdata[39:34] == 6'd0)
    else $error("ram size nonzero for invalid code");

  // every result counts at least the byte that closed the image
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[88:65] != 24'd0)
    else $error("result with zero byte count");

  // the last byte of an image shows up as a result through the s1 and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> ##1 m_axis_tvalid)
    else $error("result missing after last byte");

endmodule

bind rom_header_validator rhv_checker u_rhv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/rom_header_validator_tb.sv
// self-checking bench for the streaming cartridge header checker
module rom_header_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // counter narrower than the block default, still wide enough for the header
  localparam int CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  localparam int A_LOGO_LO = 'h104;
  localparam int A_LOGO_HI = 'h133;
  localparam int A_HDR_LO  = 'h134;
  localparam int A_HDR_HI  = 'h14C;
  localparam int A_HSUM    = 'h14D;
  localparam int A_GHI     = 'h14E;
  localparam int A_GLO     = 'h14F;
  localparam int A_TYPE    = 'h147;
  localparam int A_ROM     = 'h148;
  localparam int A_RAM     = 'h149;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_IMAGES  = 16;
  localparam int LATE_IMAGES  = 4;

  localparam logic [0:47][7:0] LOGO_REF = {
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
    8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
    8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
    8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
  };

  typedef enum int { FILL_ZERO, FILL_ONES, FILL_RAND } fill_t;

  // same layout as m_axis_tdata, msb first
  typedef struct packed {
    logic [6:0]  spare;
    logic [23:0] byte_count;
    logic [15:0] stored_gsum;
    logic [7:0]  stored_hsum;
    logic        ram_valid;
    logic [5:0]  ram_kib;
    logic [13:0] rom_kib;
    logic [7:0]  rom_code;
    logic [7:0]  cart_type;
    logic        complete;
    logic        gsum_ok;
    logic        hsum_ok;
    logic        logo_ok;
  } verdict_t;

  typedef struct {
    bit       typed;
    verdict_t v;
  } canned_t;

  typedef struct {
    int         len;
    fill_t      bg;
    bit         good;
    logic [7:0] rom_c;
    logic [7:0] ram_c;
    int         flip_at;
    bit         typed;
    verdict_t   v;
  } img_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;

  // header checker model state
  logic [CNT_BITS-1:0] p_pos  = '0;
  logic                p_logo = 1'b1;
  logic [7:0]          p_hacc = '0;
  logic [15:0]         p_gacc = '0;
  logic [7:0]          p_type = '0;
  logic [7:0]          p_rom  = '0;
  logic [7:0]          p_ram  = '0;
  logic [7:0]          p_hsum = '0;
  logic [15:0]         p_gsum = '0;

  verdict_t    verdict_q[$];
  canned_t     canned_q[$];
  logic [7:0]  img[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          gap_odds = 0;
  int          ready_odds = 0;
  bit          hold_go = 1'b0;
  logic        hold_off = 1'b0;

  rom_header_validator #(
    .COUNT_BITS(CNT_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // fills img; a good image carries the logo, the codes and both checksums
  task automatic build_image(input int len, input fill_t bg, input bit good,
                             input logic [7:0] rom_c, input logic [7:0] ram_c,
                             input int flip_at, input logic [7:0] flip_mask);
    logic [7:0]  hacc;
    logic [15:0] gacc;
    img.delete();
    for (int i = 0; i < len; i++) begin
      case (bg)
        FILL_ZERO: img.push_back(8'h00);
        FILL_ONES: img.push_back(8'hFF);
        default:   img.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (good) begin
      for (int i = 0; i < 48 && A_LOGO_LO + i < len; i++) img[A_LOGO_LO + i] = LOGO_REF[i];
      if (A_ROM < len) img[A_ROM] = rom_c;
      if (A_RAM < len) img[A_RAM] = ram_c;
      hacc = '0;
      for (int i = A_HDR_LO; i <= A_HDR_HI && i < len; i++) hacc = hacc - img[i] - 8'd1;
      if (A_HSUM < len) img[A_HSUM] = hacc;
      gacc = '0;
      for (int i = 0; i < len; i++) if (i != A_GHI && i != A_GLO) gacc = gacc + img[i];
      if (A_GLO < len) begin
        img[A_GHI] = gacc[15:8];
        img[A_GLO] = gacc[7:0];
      end
    end
    if (flip_at >= 0 && flip_at < len) img[flip_at] = img[flip_at] ^ flip_mask;
  endtask

  // leaves tvalid high after the final byte; callers that wait drop it first
  task automatic send_image();
    for (int i = 0; i < img.size(); i++) begin
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= img[i];
      s_axis_tlast  <= (i == img.size() - 1);
      do @(posedge clk); while (!s_axis_tready);
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [CNT_BITS-1:0] addr;
    logic [CNT_BITS-1:0] cnt;
    logic [7:0]          b;
    verdict_t            v;
    verdict_t            got;
    verdict_t            want;
    canned_t             canned;
    string               diff;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with none pending: %h",
                                         results_seen, got);
        end else begin
          want = verdict_q.pop_front();
          diff = "";
          if (got.logo_ok     !== want.logo_ok)     diff = {diff, " logo_ok"};
          if (got.hsum_ok     !== want.hsum_ok)     diff = {diff, " header_sum_ok"};
          if (got.gsum_ok     !== want.gsum_ok)     diff = {diff, " global_sum_ok"};
          if (got.complete    !== want.complete)    diff = {diff, " header_complete"};
          if (got.cart_type   !== want.cart_type)   diff = {diff, " cart_type"};
          if (got.rom_code    !== want.rom_code)    diff = {diff, " rom_size_code"};
          if (got.rom_kib     !== want.rom_kib)     diff = {diff, " rom_size_kib"};
          if (got.ram_kib     !== want.ram_kib)     diff = {diff, " ram_size_kib"};
          if (got.ram_valid   !== want.ram_valid)   diff = {diff, " ram_code_valid"};
          if (got.stored_hsum !== want.stored_hsum) diff = {diff, " stored_header_sum"};
          if (got.stored_gsum !== want.stored_gsum) diff = {diff, " stored_global_sum"};
          if (got.byte_count  !== want.byte_count)  diff = {diff, " byte_count"};
          if (diff != "") begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d mismatch in%s: expected %h got %h",
                                           results_seen, diff, want, got);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        b    = s_axis_tdata;
        addr = p_pos;
        if (addr >= A_LOGO_LO && addr <= A_LOGO_HI && b != LOGO_REF[addr - A_LOGO_LO])
          p_logo = 1'b0;
        if (addr >= A_HDR_LO && addr <= A_HDR_HI) p_hacc = p_hacc - b - 8'd1;
        if (addr != A_GHI && addr != A_GLO) p_gacc = p_gacc + b;
        if (addr == A_TYPE) p_type = b;
        if (addr == A_ROM)  p_rom  = b;
        if (addr == A_RAM)  p_ram  = b;
        if (addr == A_HSUM) p_hsum = b;
        if (addr == A_GHI)  p_gsum[15:8] = b;
        if (addr == A_GLO)  p_gsum[7:0]  = b;
        cnt   = (addr < CNT_MAX) ? addr + 1'b1 : addr;
        p_pos = cnt;
        if (s_axis_tlast) begin
          v             = '0;
          v.logo_ok     = (addr >= A_LOGO_HI) && p_logo;
          v.hsum_ok     = (addr >= A_HSUM) && (p_hacc == p_hsum);
          v.gsum_ok     = (addr >= A_GLO) && (p_gacc == p_gsum);
          v.complete    = (addr >= A_GLO);
          v.cart_type   = p_type;
          v.rom_code    = p_rom;
          v.rom_kib     = (p_rom <= 8'd8) ? (14'd32 << p_rom) : 14'd0;
          v.ram_valid   = (p_ram <= 8'd3);
          case (p_ram)
            8'd1:    v.ram_kib = 6'd2;
            8'd2:    v.ram_kib = 6'd8;
            8'd3:    v.ram_kib = 6'd32;
            default: v.ram_kib = 6'd0;
          endcase
          v.stored_hsum = p_hsum;
          v.stored_gsum = p_gsum;
          v.byte_count  = 24'(cnt);
          canned = canned_q.pop_front();
          verdict_q.push_back(canned.typed ? canned.v : v);
          p_pos  = '0;
          p_logo = 1'b1;
          p_hacc = '0;
          p_gacc = '0;
          p_type = '0;
          p_rom  = '0;
          p_ram  = '0;
          p_hsum = '0;
          p_gsum = '0;
        end
      end
    end
  end

  // receiver side: random stall bursts, plus the long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (ready_odds != 0 && $urandom_range(1, ready_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("rom_header_validator_tb NOT OK");
    $finish;
  end

  initial begin
    img_row_t img_tab[$];
    int       len;
    int       flip_at;
    bit       good;
    bit       late;
    logic [7:0] rom_c;
    logic [7:0] ram_c;

    img_tab = '{
      // single-byte and two-byte images: nothing captured, zero codes give 32 KiB rom, no ram
      '{1, FILL_ZERO, 1'b0, 8'h00, 8'h00, -1, 1'b1,
        '{byte_count: 24'd1, rom_kib: 14'd32, ram_valid: 1'b1, default: '0}},
      '{1, FILL_ONES, 1'b0, 8'h00, 8'h00, -1, 1'b1,
        '{byte_count: 24'd1, rom_kib: 14'd32, ram_valid: 1'b1, default: '0}},
      '{2, FILL_ZERO, 1'b0, 8'h00, 8'h00, -1, 1'b1,
        '{byte_count: 24'd2, rom_kib: 14'd32, ram_valid: 1'b1, default: '0}},
      // header sum reached but global word not
      '{'h14E, FILL_ONES, 1'b1, 8'h01, 8'h02, -1, 1'b0, '0},
      // complete header at the top valid size codes
      '{'h150, FILL_RAND, 1'b1, 8'h08, 8'h03, -1, 1'b0, '0},
      // out of range codes, global sum wraps, last logo byte damaged
      '{'h150, FILL_ONES, 1'b1, 8'h52, 8'hFF, 'h133, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (img_tab[r]) begin
      gap_odds   = 6;
      ready_odds = 6;
      build_image(img_tab[r].len, img_tab[r].bg, img_tab[r].good, img_tab[r].rom_c,
                  img_tab[r].ram_c, img_tab[r].flip_at, 8'h01);
      canned_q.push_back('{img_tab[r].typed, img_tab[r].v});
      send_image();
    end

    // receiver holds off while tiny images keep coming, so the input backs up
    s_axis_tvalid <= 1'b0;
    hold_go = 1'b1;
    @(posedge clk);
    @(negedge clk);
    gap_odds = 0;
    for (int k = 0; k < 8; k++) begin
      build_image($urandom_range(1, 3), FILL_RAND, 1'b0, 8'h00, 8'h00, -1, 8'h00);
      canned_q.push_back('{1'b0, '0});
      send_image();
    end

    for (int k = 0; k < RAND_IMAGES; k++) begin
      late = (k >= RAND_IMAGES - LATE_IMAGES);
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       ready_odds = 0;
        1:       ready_odds = 3;
        default: ready_odds = 10;
      endcase
      if (late) begin
        gap_odds   = 0;
        ready_odds = 0;
      end
      // mostly short images, with every eighth one long enough to reach the header sums
      if (k % 8 == 7) begin
        len  = $urandom_range(A_GLO - 1, A_GLO + 4);
        good = ($urandom_range(0, 9) < 8);
      end else begin
        len  = $urandom_range(1, 24);
        good = $urandom_range(0, 1);
      end
      rom_c   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 9));
      ram_c   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 4));
      flip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(A_LOGO_LO - 4, A_GLO) : -1;
      build_image(len, FILL_RAND, good, rom_c, ram_c, flip_at,
                  8'(1 << $urandom_range(0, 7)));
      canned_q.push_back('{1'b0, '0});
      send_image();
    end

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rom_header_validator_tb OK");
    end else begin
      $display("rom_header_validator_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rhv_pkg.sv
rtl/core/rhv_logo_rom.sv
rtl/core/rhv_front.sv
rtl/core/rhv_check.sv
rtl/core/rom_header_validator.sv
rtl/core/rhv_checker.sv
bench/rom_header_validator_tb.sv
